// ===== rtl/ppd_pkg.sv =====
// Package for the periodic point distance block: widths, register indexes,
// reset values, pipeline depths and the shared configuration struct.
// It depends on nothing and is used by every module of the block.
package ppd_pkg;

   localparam int COORD_W   = 24;
   localparam int BOX_W     = 11;
   localparam int FRAC_BITS = 12;

   // sqrt(3)/2 as an unsigned fraction with HEX_Q fraction bits.
   localparam int HEX_Q              = 16;
   localparam logic [HEX_Q-1:0] HEX_SCALE = 16'd56756;
   localparam int HEX_PROD_W         = BOX_W + HEX_Q;
   localparam int HEX_SHIFT          = HEX_Q - FRAC_BITS;

   localparam int PER_W  = BOX_W + FRAC_BITS;
   localparam int MAG_W  = (PER_W > COORD_W) ? PER_W : COORD_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   localparam int DIST_W = 26;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam int SAT_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

   localparam int AXIS_LAT = 4;
   localparam int LATENCY  = AXIS_LAT + 1 + ROOT_W;

   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOX_WIDTH       = 2'd0,
      REG_BOX_HEIGHT      = 2'd1,
      REG_HEXAGONAL_MODE  = 2'd2,
      REG_PERIODIC_ENABLE = 2'd3
   } csr_index_type;

   localparam logic [BOX_W-1:0] BOX_WIDTH_RST  = 11'd64;
   localparam logic [BOX_W-1:0] BOX_HEIGHT_RST = 11'd64;

   typedef struct packed {
      logic [PER_W-1:0] period_x;
      logic [PER_W-1:0] period_y;
      logic             wrap;
   } cfg_type;

endpackage

// ===== rtl/ppd_csr.sv =====
// Configuration registers of the periodic point distance block.
// Holds the box size and mode bits and derives the registered x and y periods.
// Depends on ppd_pkg.
module ppd_csr
   import ppd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BOX_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   logic [BOX_W-1:0]      box_width_ff, box_width_in;
   logic [BOX_W-1:0]      box_height_ff, box_height_in;
   logic                  hex_ff, hex_in;
   logic                  periodic_ff, periodic_in;
   logic [PER_W-1:0]      period_x_ff, period_x_in;
   logic [PER_W-1:0]      period_y_ff, period_y_in;
   logic [HEX_PROD_W-1:0] hex_prod;

   always_comb begin
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      hex_in        = hex_ff;
      periodic_in   = periodic_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BOX_WIDTH:       box_width_in  = csr_wdata;
            REG_BOX_HEIGHT:      box_height_in = csr_wdata;
            REG_HEXAGONAL_MODE:  hex_in        = csr_wdata[0];
            REG_PERIODIC_ENABLE: periodic_in   = csr_wdata[0];
            default:             ;
         endcase
      end
   end

   // The hexagonal period is the height times sqrt(3)/2, truncated.
   assign hex_prod    = HEX_PROD_W'(box_height_ff) * HEX_PROD_W'(HEX_SCALE);
   assign period_x_in = PER_W'(box_width_ff) << FRAC_BITS;
   assign period_y_in = hex_ff ? PER_W'(hex_prod >> HEX_SHIFT)
                               : PER_W'(box_height_ff) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff  <= BOX_WIDTH_RST;
         box_height_ff <= BOX_HEIGHT_RST;
         hex_ff        <= 1'b0;
         periodic_ff   <= 1'b0;
      end else begin
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
         hex_ff        <= hex_in;
         periodic_ff   <= periodic_in;
      end
   end

   always_ff @(posedge clock) begin
      period_x_ff <= period_x_in;
      period_y_ff <= period_y_in;
   end

   assign cfg.period_x = period_x_ff;
   assign cfg.period_y = period_y_ff;
   assign cfg.wrap     = periodic_ff;

   a_square_period_y: assert property (@(posedge clock) disable iff (reset)
      (!hex_ff && !csr_we) |=> (period_y_ff == (PER_W'(box_height_ff) << FRAC_BITS)))
      else $error("y period does not follow the box height in square mode");

endmodule

// ===== rtl/ppd_axis.sv =====
// One axis of the distance datapath: difference magnitude, wrapped magnitude,
// both squares and the minimum-image selection over four register stages.
// Depends on ppd_pkg.
module ppd_axis
   import ppd_pkg::*;
(
   input  logic                      clock,
   input  logic signed [COORD_W-1:0] a,
   input  logic signed [COORD_W-1:0] b,
   input  logic [PER_W-1:0]          period,
   input  logic                      wrap,
   output logic [SQ_W-1:0]           term
);

   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]        diff_neg;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [MAG_W:0]   wdiff;
   logic [MAG_W:0]          wdiff_neg;
   logic [MAG_W-1:0]        direct_ff;
   logic [MAG_W-1:0]        wmag_ff, wmag_in;
   logic [SQ_W-1:0]         sq_direct_ff, sq_wrap_ff;
   logic [SQ_W-1:0]         term_ff, term_in;

   // Stage 1: magnitude of the signed difference.
   assign diff     = {a[COORD_W-1], a} - {b[COORD_W-1], b};
   assign diff_neg = -diff;
   assign mag_in   = diff[COORD_W] ? MAG_W'(diff_neg[COORD_W-1:0])
                                   : MAG_W'(diff[COORD_W-1:0]);

   // Stage 2: magnitude of the period minus the direct magnitude.
   assign wdiff     = $signed({1'b0, MAG_W'(period)}) - $signed({1'b0, mag_ff});
   assign wdiff_neg = -wdiff;
   assign wmag_in   = wdiff[MAG_W] ? wdiff_neg[MAG_W-1:0] : wdiff[MAG_W-1:0];

   // Stage 4: the wrapped term wins ties, which gives the same value.
   assign term_in = (wrap && !(sq_direct_ff < sq_wrap_ff)) ? sq_wrap_ff : sq_direct_ff;

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      direct_ff    <= mag_ff;
      wmag_ff      <= wmag_in;
      sq_direct_ff <= direct_ff * direct_ff;
      sq_wrap_ff   <= wmag_ff * wmag_ff;
      term_ff      <= term_in;
   end

   assign term = term_ff;

endmodule

// ===== rtl/ppd_sqrt.sv =====
// Pipelined truncating integer square root, one result bit per stage.
// Each stage brings down two radicand bits and does one trial subtraction.
// Depends on ppd_pkg.
module ppd_sqrt
   import ppd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  radicand,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root
);

   logic [REM_W-1:0]  rem_tap  [ROOT_W+1];
   logic [ROOT_W-1:0] root_tap [ROOT_W+1];
   logic [SUM_W-1:0]  rad_tap  [ROOT_W+1];
   logic [ROOT_W:0]   vld_tap;

   assign rem_tap[0]  = '0;
   assign root_tap[0] = '0;
   assign rad_tap[0]  = radicand;
   assign vld_tap[0]  = in_valid;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [REM_W-1:0]  cat;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_ff, rem_in;
      logic [ROOT_W-1:0] root_ff, root_in;
      logic [SUM_W-1:0]  rad_ff, rad_in;
      logic              vld_ff;

      always_comb begin
         cat   = {rem_tap[s][REM_W-3:0], rad_tap[s][SUM_W-1 -: 2]};
         trial = REM_W'({root_tap[s], 2'b01});
         if (cat >= trial) begin
            rem_in  = cat - trial;
            root_in = {root_tap[s][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cat;
            root_in = {root_tap[s][ROOT_W-2:0], 1'b0};
         end
         rad_in = rad_tap[s] << 2;
      end

      always_ff @(posedge clock) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_tap[s];
         end
      end

      assign rem_tap[s+1]  = rem_ff;
      assign root_tap[s+1] = root_ff;
      assign rad_tap[s+1]  = rad_ff;
      assign vld_tap[s+1]  = vld_ff;
   end

   assign out_valid = vld_tap[ROOT_W];
   assign root      = root_tap[ROOT_W];

   // A floor square root leaves a remainder of at most twice the root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_tap[ROOT_W] <= REM_W'({root_tap[ROOT_W], 1'b0})))
      else $error("square root remainder exceeds twice the root");

endmodule

// ===== rtl/periodic_point_distance.sv =====
// Top level of the periodic point distance block: configuration registers,
// three axis datapaths, the sum stage and the pipelined square root.
// Depends on ppd_pkg, ppd_csr, ppd_axis and ppd_sqrt.
//
// Usage: a request carries two 3D points in signed Q12.12 on the req_ ports
// and is taken at a rising edge with start high and busy low. busy never
// rises, so a new request may enter on every clock. Each request yields one
// distance on rsp_distance (unsigned Q14.12, truncated square root), marked by
// rsp_valid for exactly one cycle, after the request has passed through
// four axis stages (difference, wrap, square, minimum), one sum stage and one
// stage per root bit (25 at 12 fraction bits). Throughput is one request per
// cycle; the square root pipeline holds most of the stages of the path.
// The csr_ port writes box_width (0), box_height (1), hexagonal_mode (2) and
// periodic_enable (3); write it only with no requests in flight.
// Synchronous reset empties the pipeline and restores the register defaults
// (64 by 64 box, square, non-periodic). The receiver cannot stall: every
// distance must be taken in the cycle rsp_valid is high.
module periodic_point_distance
   import ppd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_a_x,
   input  logic signed [COORD_W-1:0] req_a_y,
   input  logic signed [COORD_W-1:0] req_a_z,
   input  logic signed [COORD_W-1:0] req_b_x,
   input  logic signed [COORD_W-1:0] req_b_y,
   input  logic signed [COORD_W-1:0] req_b_z,
   output logic                      rsp_valid,
   output logic [DIST_W-1:0]         rsp_distance,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [BOX_W-1:0]          csr_wdata
);

   cfg_type           cfg;
   logic              accept;
   logic [SQ_W-1:0]   term_x, term_y, term_z;
   logic [AXIS_LAT:0] pipe_vld_ff, pipe_vld_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [ROOT_W-1:0] root;
   logic [SAT_W-1:0]  root_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ppd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppd_axis u_axis_x (
      .clock  (clock),
      .a      (req_a_x),
      .b      (req_b_x),
      .period (cfg.period_x),
      .wrap   (cfg.wrap),
      .term   (term_x)
   );

   ppd_axis u_axis_y (
      .clock  (clock),
      .a      (req_a_y),
      .b      (req_b_y),
      .period (cfg.period_y),
      .wrap   (cfg.wrap),
      .term   (term_y)
   );

   // The z axis never wraps.
   ppd_axis u_axis_z (
      .clock  (clock),
      .a      (req_a_z),
      .b      (req_b_z),
      .period ('0),
      .wrap   (1'b0),
      .term   (term_z)
   );

   assign pipe_vld_in = {pipe_vld_ff[AXIS_LAT-1:0], accept};
   assign sum_in      = SUM_W'(term_x) + SUM_W'(term_y) + SUM_W'(term_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else begin
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   ppd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_vld_ff[AXIS_LAT]),
      .radicand  (sum_ff),
      .out_valid (rsp_valid),
      .root      (root)
   );

   assign root_ext     = SAT_W'(root);
   assign rsp_distance = (root_ext > SAT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted request produced no response");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching request");

endmodule
